// ===== rtl/core/illcr_pkg.sv =====
// illcr_pkg: shared types and constants for the least-loaded interrupt router.
// Used by every module under rtl/core; depends on nothing.
package illcr_pkg;

    localparam int MAX_CORES_DEF       = 16;
    localparam int IRQ_LINES_DEF       = 16;
    localparam int BALANCE_DIVISOR_DEF = 10;

    localparam logic [63:0] COUNT_INIT_MIN = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] COUNT_NEAR_MAX = 64'hFFFF_FFFF_FFFF_FFFE;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYM_IO   = 2'd0,
        CFG_BAL_EN   = 2'd1,
        CFG_CORE_CNT = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0] irq;
        logic [3:0] core_id;
    } in_item_t;

    typedef struct packed {
        logic       eoi_to_apic;
        logic [3:0] eoi_irq;
        logic       route_valid;
        logic [3:0] route_core;
        logic       counts_cleared;
    } out_item_t;

    // classified command passed from front to back
    typedef struct packed {
        logic [3:0] irq;
        logic [3:0] core_id;
        logic       has_counter;
        logic       eoi_to_apic;
        logic       balance_en;
        logic [4:0] scan;
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/core/irq_least_loaded_core_router.sv =====
// irq_least_loaded_core_router: top level, front / queue / back.
// Depends on illcr_pkg, illcr_front, illcr_fifo, illcr_back.
//
//   channel   signals                              direction
//   in        in_valid, in_stall, in_data          item in   (irq, core_id)
//   out       out_valid, out_stall, out_data       result out (EOI target, route)
//   cfg       cfg_wr_en, cfg_index, cfg_data       register write, no read-back
//
// An item passes from input transfer through the hold register, queue, count read, increment
// and result register; a balancing step adds a scan of core_count counts, one count read per
// cycle from the count memory's single read port, and a clearing pass over them when needed.
// After reset a clearing pass writes 2**(clog2(MAX_CORES)+clog2(IRQ_LINES))
// entries, one a cycle (256 by default), with in_stall high.
// The queue lets the front take items while the back works or out_stall is high.
module irq_least_loaded_core_router #(
    parameter int MAX_CORES       = illcr_pkg::MAX_CORES_DEF,
    parameter int IRQ_LINES       = illcr_pkg::IRQ_LINES_DEF,
    parameter int BALANCE_DIVISOR = illcr_pkg::BALANCE_DIVISOR_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  illcr_pkg::in_item_t              in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output illcr_pkg::out_item_t             out_data,
    input  logic                             cfg_wr_en,
    input  logic [illcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [illcr_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic            init_busy;
    logic            q_full, q_empty, q_push, q_pop;
    illcr_pkg::cmd_t q_din, q_dout;

    illcr_front #(
        .MAX_CORES (MAX_CORES),
        .IRQ_LINES (IRQ_LINES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_din     (q_din)
    );

    illcr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    illcr_back #(
        .MAX_CORES       (MAX_CORES),
        .IRQ_LINES       (IRQ_LINES),
        .BALANCE_DIVISOR (BALANCE_DIVISOR)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_dout    (q_dout),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/illcr_front.sv =====
// illcr_front: input transfer, configuration registers and item classification.
// Depends on illcr_pkg.
module illcr_front #(
    parameter int MAX_CORES = illcr_pkg::MAX_CORES_DEF,
    parameter int IRQ_LINES = illcr_pkg::IRQ_LINES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  illcr_pkg::in_item_t                 in_data,
    input  logic                                cfg_wr_en,
    input  logic [illcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [illcr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                init_busy,
    input  logic                                q_full,
    output logic                                q_push,
    output illcr_pkg::cmd_t                     q_din
);

    logic            sym_io_reg;
    logic            bal_en_reg;
    logic [4:0]      core_cnt_reg;
    logic            hold_valid_reg, hold_valid_next;
    illcr_pkg::cmd_t hold_reg;
    illcr_pkg::cmd_t cmd;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            sym_io_reg   <= 1'b0;
            bal_en_reg   <= 1'b0;
            core_cnt_reg <= 5'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                illcr_pkg::CFG_SYM_IO:   sym_io_reg   <= cfg_data[0];
                illcr_pkg::CFG_BAL_EN:   bal_en_reg   <= cfg_data[0];
                illcr_pkg::CFG_CORE_CNT: core_cnt_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cmd.irq         = in_data.irq;
        cmd.core_id     = in_data.core_id;
        cmd.has_counter = (32'(in_data.core_id) < MAX_CORES) && (32'(in_data.irq) < IRQ_LINES);
        cmd.eoi_to_apic = sym_io_reg;
        cmd.balance_en  = bal_en_reg;
        cmd.scan        = (32'(core_cnt_reg) > MAX_CORES) ? 5'(MAX_CORES) : core_cnt_reg;
    end

    assign q_push   = hold_valid_reg && !q_full;
    assign q_din    = hold_reg;
    assign in_stall = init_busy || (hold_valid_reg && q_full);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
            hold_valid_next = 1'b1;
        else if (q_push)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk) begin
        if (accept)
            hold_reg <= cmd;
    end

endmodule

// ===== rtl/core/illcr_fifo.sv =====
// illcr_fifo: short command queue between front and back.
// Depends on illcr_pkg.
module illcr_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  illcr_pkg::cmd_t din,
    input  logic            pop,
    output illcr_pkg::cmd_t dout,
    output logic            full,
    output logic            empty
);

    localparam int PW = (illcr_pkg::QUEUE_DEPTH > 1) ? $clog2(illcr_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(illcr_pkg::QUEUE_DEPTH + 1);

    illcr_pkg::cmd_t slot_reg [illcr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   fill_reg, fill_next;

    assign full  = (fill_reg == NW'(illcr_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (32'(wr_ptr_reg) == illcr_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (32'(rd_ptr_reg) == illcr_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== rtl/core/illcr_back.sv =====
// illcr_back: count memory, increment, least-loaded scan, clear sweep, result register.
// Depends on illcr_pkg.
module illcr_back #(
    parameter int MAX_CORES       = illcr_pkg::MAX_CORES_DEF,
    parameter int IRQ_LINES       = illcr_pkg::IRQ_LINES_DEF,
    parameter int BALANCE_DIVISOR = illcr_pkg::BALANCE_DIVISOR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  illcr_pkg::cmd_t      q_dout,
    output logic                 q_pop,
    output logic                 init_busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output illcr_pkg::out_item_t out_data
);

    localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int IW    = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
    localparam int AW    = CW + IW;
    localparam int DEPTH = 1 << AW;
    localparam int RW    = (BALANCE_DIVISOR > 1) ? $clog2(BALANCE_DIVISOR) : 1;

    // count plus its residue modulo the divisor, kept in step with it
    typedef struct packed {
        logic [63:0]   cnt;
        logic [RW-1:0] res;
    } entry_t;

    typedef enum logic [8:0] {
        ST_INIT  = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_RD    = 9'b000000100,
        ST_INC   = 9'b000001000,
        ST_SCAN  = 9'b000010000,
        ST_DRAIN = 9'b000100000,
        ST_CHK   = 9'b001000000,
        ST_CLR   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    entry_t mem [DEPTH];
    entry_t rdata_reg;
    logic   we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata;

    state_t state_reg, state_next;
    illcr_pkg::cmd_t cur_reg, cur_next;
    logic [AW-1:0] init_addr_reg, init_addr_next;
    logic [4:0]    idx_reg, idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [4:0]    cmp_idx_reg, cmp_idx_next;
    logic [63:0]   minv_reg, minv_next;
    logic [4:0]    best_reg, best_next;
    logic          clear_reg, clear_next;
    logic          route_reg, route_next;
    logic          out_valid_reg, out_valid_next;
    illcr_pkg::out_item_t out_reg, out_next;

    logic [63:0] inc_cnt;
    logic [RW:0] res_inc;
    logic [RW-1:0] new_res;
    logic        last_idx;

    assign init_busy = (state_reg == ST_INIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign inc_cnt  = rdata_reg.cnt + 64'd1;
    assign res_inc  = {1'b0, rdata_reg.res} + 1'b1;
    assign new_res  = ((inc_cnt == '0) || (res_inc == (RW+1)'(BALANCE_DIVISOR)))
                      ? '0 : res_inc[RW-1:0];
    assign last_idx = (idx_reg == cur_reg.scan - 5'd1);

    always_comb
    begin
        if (state_reg == ST_SCAN)
            raddr = {CW'(idx_reg), IW'(cur_reg.irq)};
        else
            raddr = {CW'(cur_reg.core_id), IW'(cur_reg.irq)};
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        init_addr_next = init_addr_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = idx_reg;
        minv_next      = minv_reg;
        best_next      = best_reg;
        clear_next     = clear_reg;
        route_next     = route_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = {CW'(idx_reg), IW'(cur_reg.irq)};
        wdata          = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // scan compare, one read behind the address
        if (cmp_vld_reg)
        begin
            if (rdata_reg.cnt < minv_reg)
            begin
                minv_next = rdata_reg.cnt;
                best_next = cmp_idx_reg;
            end
            else if (rdata_reg.cnt >= illcr_pkg::COUNT_NEAR_MAX)
                clear_next = 1'b1;
        end

        case (state_reg)
            ST_INIT:
            begin
                we             = 1'b1;
                waddr          = init_addr_reg;
                init_addr_next = init_addr_reg + 1'b1;
                if (init_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_dout;
                    route_next = 1'b0;
                    clear_next = 1'b0;
                    best_next  = '0;
                    minv_next  = illcr_pkg::COUNT_INIT_MIN;
                    state_next = q_dout.has_counter ? ST_RD : ST_OUT;
                end
            end
            ST_RD:
                state_next = ST_INC;
            ST_INC:
            begin
                we        = 1'b1;
                waddr     = {CW'(cur_reg.core_id), IW'(cur_reg.irq)};
                wdata.cnt = inc_cnt;
                wdata.res = new_res;
                idx_next  = '0;
                if ((inc_cnt != '0) && (new_res == '0) && cur_reg.balance_en)
                begin
                    route_next = 1'b1;
                    state_next = (cur_reg.scan == '0) ? ST_OUT : ST_SCAN;
                end
                else
                    state_next = ST_OUT;
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                idx_next     = idx_reg + 5'd1;
                if (last_idx)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_CHK;
            ST_CHK:
            begin
                idx_next   = '0;
                state_next = clear_reg ? ST_CLR : ST_OUT;
            end
            ST_CLR:
            begin
                we       = 1'b1;
                idx_next = idx_reg + 5'd1;
                if (last_idx)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next         = 1'b1;
                    out_next.eoi_to_apic    = cur_reg.eoi_to_apic;
                    out_next.eoi_irq        = cur_reg.irq;
                    out_next.route_valid    = route_reg;
                    out_next.route_core     = best_reg[3:0];
                    out_next.counts_cleared = clear_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        minv_reg    <= minv_next;
        best_reg    <= best_next;
        clear_reg   <= clear_next;
        route_reg   <= route_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

endmodule

// ===== rtl/core/illcr_checker.sv =====
// illcr_checker: port-level assertions for irq_least_loaded_core_router, and its bind.
// Depends on illcr_pkg.
module illcr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input illcr_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_stall,
    input illcr_pkg::out_item_t out_data
);

    // stalled input offer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled input offer changed");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // no route, no core
    a_route_core: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.route_valid |-> out_data.route_core == 4'd0)
        else $error("route_core set without route_valid");

    // counts are cleared only on a balancing step
    a_clear_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.counts_cleared |-> out_data.route_valid)
        else $error("counts_cleared without route_valid");

    // clearing pass holds off input right after reset
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall && !out_valid)
        else $error("input taken during clearing pass");

endmodule

bind irq_least_loaded_core_router illcr_checker u_illcr_checker (.*);
